/* rtl/core/tgb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgb_pkg
// Types and constants shared by the triangle grid binner.
// ----------------------------------------------------------------------------
package tgb_pkg;

	localparam int COORD_BITS = 24;
	localparam int STEP_BITS  = 23;
	localparam int PAD_BITS   = 16;
	localparam int CNT_BITS   = 4;
	localparam int TRI_BITS   = 16;
	localparam int IDX_BITS   = 3;
	localparam int ACC_BITS   = 29;
	localparam int CFG_BITS   = 32;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd1;
	localparam logic [2:0] REG_STEP_X   = 3'd2;
	localparam logic [2:0] REG_STEP_Z   = 3'd3;
	localparam logic [2:0] REG_TILES_X  = 3'd4;
	localparam logic [2:0] REG_TILES_Z  = 3'd5;
	localparam logic [2:0] REG_PADDING  = 3'd6;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] az;
		logic signed [COORD_BITS-1:0] bx;
		logic signed [COORD_BITS-1:0] bz;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cz;
		logic [TRI_BITS-1:0]          tri_number;
	} item_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] tile_col;
		logic [IDX_BITS-1:0] tile_row;
		logic [TRI_BITS-1:0] tri_out;
		logic                last_hit;
	} result_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] lo_x;
		logic signed [COORD_BITS-1:0] hi_x;
		logic signed [COORD_BITS-1:0] lo_z;
		logic signed [COORD_BITS-1:0] hi_z;
		logic [TRI_BITS-1:0]          tri_id;
	} box_t;

	typedef struct packed {
		logic valid;
		box_t box;
	} box_q_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] origin_x;
		logic signed [COORD_BITS-1:0] origin_z;
		logic [STEP_BITS-1:0]         step_x;
		logic [STEP_BITS-1:0]         step_z;
		logic [CNT_BITS-1:0]          tiles_x;
		logic [CNT_BITS-1:0]          tiles_z;
		logic [PAD_BITS-1:0]          padding;
	} cfg_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_FLUSH
	} back_state_t;

endpackage

/* rtl/core/triangle_grid_binner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_grid_binner
// Bins triangles into the tiles of a uniform X/Z grid by bounding box.
// ----------------------------------------------------------------------------
// Each pushed triangle yields one word per overlapping tile, X-major then Z,
// with last_hit set on the final one; a triangle with no overlap yields none.
// The front computes the bounding box in the accept cycle and holds up to two
// boxes; the back tests one tile per cycle unless a blocked hit stalls it, and
// takes each triangle from the idle state through a scan of every tile and a
// flush state. Configuration writes are always ready and must only be made
// while the block is idle.
module triangle_grid_binner #(
	parameter int MAX_TILES_X = 8,
	parameter int MAX_TILES_Z = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  tgb_pkg::item_t                item,
	output logic                          empty,
	input  logic                          pop,
	output tgb_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [tgb_pkg::CFG_BITS-1:0]  cfg_data
);
	import tgb_pkg::*;

	cfg_t   cfg_q;
	box_q_t head;
	logic   head_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_z <= '0;
			cfg_q.step_x   <= STEP_BITS'(256);
			cfg_q.step_z   <= STEP_BITS'(256);
			cfg_q.tiles_x  <= CNT_BITS'(8);
			cfg_q.tiles_z  <= CNT_BITS'(8);
			cfg_q.padding  <= PAD_BITS'(179);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ORIGIN_X: cfg_q.origin_x <= $signed(cfg_data[COORD_BITS-1:0]);
				REG_ORIGIN_Z: cfg_q.origin_z <= $signed(cfg_data[COORD_BITS-1:0]);
				REG_STEP_X:   cfg_q.step_x   <= cfg_data[STEP_BITS-1:0];
				REG_STEP_Z:   cfg_q.step_z   <= cfg_data[STEP_BITS-1:0];
				REG_TILES_X:  cfg_q.tiles_x  <= cfg_data[CNT_BITS-1:0];
				REG_TILES_Z:  cfg_q.tiles_z  <= cfg_data[CNT_BITS-1:0];
				REG_PADDING:  cfg_q.padding  <= cfg_data[PAD_BITS-1:0];
				default: ;
			endcase
		end
	end

	tgb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.pop    (head_pop),
		.head   (head)
	);

	tgb_back #(
		.MAX_TILES_X (MAX_TILES_X),
		.MAX_TILES_Z (MAX_TILES_Z)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.head_pop (head_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

/* rtl/core/tgb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgb_front
// Accepts triangles, forms the X/Z bounding box and queues it (two words).
// ----------------------------------------------------------------------------
module tgb_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  tgb_pkg::item_t item,
	input  logic           pop,
	output tgb_pkg::box_q_t head
);
	import tgb_pkg::*;

	box_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	box_t       box;
	logic       wr_en;
	logic       rd_en;

	function automatic logic signed [COORD_BITS-1:0] min3(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b,
		input logic signed [COORD_BITS-1:0] c
	);
		logic signed [COORD_BITS-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] max3(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b,
		input logic signed [COORD_BITS-1:0] c
	);
		logic signed [COORD_BITS-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	always_comb begin
		box.lo_x   = min3(item.ax, item.bx, item.cx);
		box.hi_x   = max3(item.ax, item.bx, item.cx);
		box.lo_z   = min3(item.az, item.bz, item.cz);
		box.hi_z   = max3(item.az, item.bz, item.cz);
		box.tri_id = item.tri_number;
	end

	assign full       = (cnt_q == 2'd2);
	assign wr_en      = push && !full;
	assign rd_en      = pop && (cnt_q != 2'd0);
	assign head.valid = (cnt_q != 2'd0);
	assign head.box   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wr_q <= !wr_q;
			if (rd_en) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_q] <= box;
	end

endmodule

/* rtl/core/tgb_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgb_back
// Scans the grid for the queued box one tile per cycle, stalling while a hit is blocked, and emits hit words.
// ----------------------------------------------------------------------------
module tgb_back #(
	parameter int MAX_TILES_X = 8,
	parameter int MAX_TILES_Z = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tgb_pkg::cfg_t    cfg,
	input  tgb_pkg::box_q_t  head,
	output logic             head_pop,
	output logic             empty,
	input  logic             pop,
	output tgb_pkg::result_t result
);
	import tgb_pkg::*;

	localparam int XW = (MAX_TILES_X > 1) ? $clog2(MAX_TILES_X) : 1;
	localparam int ZW = (MAX_TILES_Z > 1) ? $clog2(MAX_TILES_Z) : 1;

	back_state_t state_q, state_d;

	logic [CNT_BITS-1:0] nx, nz;
	logic [XW-1:0]       xi_q;
	logic [ZW-1:0]       zi_q;
	logic                x_end, z_end;

	logic signed [ACC_BITS-1:0] lo_x_q, hi_x_q, lo_z_q, hi_z_q;
	logic signed [ACC_BITS-1:0] lo_x0, hi_x0, lo_z0, hi_z0;
	logic signed [ACC_BITS-1:0] sx, sz, pad, ox, oz;
	logic signed [ACC_BITS-1:0] blo_x, bhi_x, blo_z, bhi_z;
	box_t                       box_q;

	logic                tile_hit;
	logic                pend_valid_q;
	logic [IDX_BITS-1:0] pend_col_q, pend_row_q;

	result_t    mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       out_full;
	logic       out_pop;

	logic load, advance, push_out, push_last, set_pend, clr_pend;

	function automatic logic signed [ACC_BITS-1:0] sext(input logic [COORD_BITS-1:0] v);
		return $signed({{(ACC_BITS-COORD_BITS){v[COORD_BITS-1]}}, v});
	endfunction

	assign nx = (cfg.tiles_x > CNT_BITS'(MAX_TILES_X)) ? CNT_BITS'(MAX_TILES_X) : cfg.tiles_x;
	assign nz = (cfg.tiles_z > CNT_BITS'(MAX_TILES_Z)) ? CNT_BITS'(MAX_TILES_Z) : cfg.tiles_z;

	assign sx  = $signed({{(ACC_BITS-STEP_BITS){1'b0}}, cfg.step_x});
	assign sz  = $signed({{(ACC_BITS-STEP_BITS){1'b0}}, cfg.step_z});
	assign pad = $signed({{(ACC_BITS-PAD_BITS){1'b0}}, cfg.padding});
	assign ox  = sext(cfg.origin_x);
	assign oz  = sext(cfg.origin_z);

	assign lo_x0 = ox - pad;
	assign hi_x0 = ox + sx + pad;
	assign lo_z0 = oz - pad;
	assign hi_z0 = oz + sz + pad;

	assign blo_x = sext(box_q.lo_x);
	assign bhi_x = sext(box_q.hi_x);
	assign blo_z = sext(box_q.lo_z);
	assign bhi_z = sext(box_q.hi_z);

	assign tile_hit = !(hi_x_q < blo_x || lo_x_q > bhi_x)
		&& !(hi_z_q < blo_z || lo_z_q > bhi_z);

	assign x_end = (CNT_BITS'(xi_q) == nx - CNT_BITS'(1));
	assign z_end = (CNT_BITS'(zi_q) == nz - CNT_BITS'(1));

	assign out_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign out_pop  = pop && !empty;
	assign result   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		head_pop  = 1'b0;
		load      = 1'b0;
		advance   = 1'b0;
		push_out  = 1'b0;
		push_last = 1'b0;
		set_pend  = 1'b0;
		clr_pend  = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (head.valid) begin
					head_pop = 1'b1;
					load     = 1'b1;
					if (nx != '0 && nz != '0) state_d = B_SCAN;
				end
			end
			B_SCAN: begin
				if (!(tile_hit && pend_valid_q && out_full)) begin
					advance = 1'b1;
					if (tile_hit) begin
						set_pend = 1'b1;
						push_out = pend_valid_q;
					end
					if (x_end && z_end) state_d = B_FLUSH;
				end
			end
			B_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = B_IDLE;
				end else if (!out_full) begin
					push_out  = 1'b1;
					push_last = 1'b1;
					clr_pend  = 1'b1;
					state_d   = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			xi_q         <= '0;
			zi_q         <= '0;
			wr_q         <= 1'b0;
			rd_q         <= 1'b0;
			cnt_q        <= 2'd0;
		end else begin
			if (set_pend) pend_valid_q <= 1'b1;
			else if (clr_pend) pend_valid_q <= 1'b0;
			if (load) begin
				xi_q <= '0;
				zi_q <= '0;
			end else if (advance) begin
				if (z_end) begin
					zi_q <= '0;
					xi_q <= xi_q + XW'(1);
				end else begin
					zi_q <= zi_q + ZW'(1);
				end
			end
			if (push_out) wr_q <= !wr_q;
			if (out_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push_out} - {1'b0, out_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			box_q  <= head.box;
			lo_x_q <= lo_x0;
			hi_x_q <= hi_x0;
			lo_z_q <= lo_z0;
			hi_z_q <= hi_z0;
		end else if (advance) begin
			if (z_end) begin
				lo_z_q <= lo_z0;
				hi_z_q <= hi_z0;
				lo_x_q <= lo_x_q + sx;
				hi_x_q <= hi_x_q + sx;
			end else begin
				lo_z_q <= lo_z_q + sz;
				hi_z_q <= hi_z_q + sz;
			end
		end
		if (set_pend) begin
			pend_col_q <= IDX_BITS'(xi_q);
			pend_row_q <= IDX_BITS'(zi_q);
		end
		if (push_out) begin
			mem_q[wr_q].tile_col <= pend_col_q;
			mem_q[wr_q].tile_row <= pend_row_q;
			mem_q[wr_q].tri_out  <= box_q.tri_id;
			mem_q[wr_q].last_hit <= push_last;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_SCAN && tile_hit && pend_valid_q && out_full)
		|=> (state_q == B_SCAN && $stable(xi_q) && $stable(zi_q)))
		else $error("scan moved on while a hit was blocked");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_IDLE) |-> !pend_valid_q)
		else $error("pending hit left behind at end of triangle");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> (state_q == B_IDLE && head.valid))
		else $error("box taken outside idle");
`endif

endmodule
